// ===== rtl/arm_data_processing_alu_top_macros.svh =====
// Assertion macros shared by the RTL.
// ADP_ASSERT is checked only outside reset; ADP_ASSERT_RST is checked always.
`ifndef ARM_DATA_PROCESSING_ALU_TOP_MACROS_SVH
`define ARM_DATA_PROCESSING_ALU_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ADP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ADP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ADP_ASSERT(label, prop, msg)
`define ADP_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/adp_pkg.sv =====
package adp_pkg;

    localparam int DATA_W  = 32;
    localparam int AMT_W   = 8;
    localparam int SH_W    = $clog2(DATA_W);
    localparam int FLAGS_W = 4;
    localparam int REG_W   = 4;

    // NZCV bit positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // Data-processing opcodes handled here
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13
    } t_opcode;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    // Barrel shifter request
    typedef struct packed {
        logic [DATA_W-1:0] value;
        t_shift            kind;
        logic [AMT_W-1:0]  amount;
        logic              cin;
    } t_shift_req;

    // ALU answer
    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              carry;
        logic              wr_en;
        logic              illegal;
    } t_alu_res;

endpackage

// ===== rtl/adp_intf.sv =====
// Input word: instruction and operands
interface adp_in_if;
    logic                                valid;
    logic                                ready;
    logic [adp_pkg::DATA_W-1:0]          instruction;
    logic [adp_pkg::DATA_W-1:0]          rn_value;
    logic [adp_pkg::DATA_W-1:0]          rm_value;
    logic [adp_pkg::DATA_W-1:0]          rs_value;
    logic [adp_pkg::FLAGS_W-1:0]         flags_in;

    modport source (output valid, instruction, rn_value, rm_value, rs_value, flags_in,
                    input ready);
    modport sink   (input valid, instruction, rn_value, rm_value, rs_value, flags_in,
                    output ready);
endinterface

// Output word: writeback and flags
interface adp_out_if;
    logic                                valid;
    logic                                ready;
    logic [adp_pkg::DATA_W-1:0]          result_value;
    logic [adp_pkg::REG_W-1:0]           dest_index;
    logic                                write_enable;
    logic [adp_pkg::FLAGS_W-1:0]         flags_out;
    logic                                illegal_op;

    modport source (output valid, result_value, dest_index, write_enable, flags_out,
                    illegal_op, input ready);
    modport sink   (input valid, result_value, dest_index, write_enable, flags_out,
                    illegal_op, output ready);
endinterface

// ===== rtl/adp_shifter.sv =====
module adp_shifter (
    input  adp_pkg::t_shift_req          i_req,
    output logic [adp_pkg::DATA_W-1:0]   o_opnd,
    output logic                         o_carry
);

    localparam int DW = adp_pkg::DATA_W;
    localparam int SW = adp_pkg::SH_W;
    localparam int AW = adp_pkg::AMT_W;

    logic [DW-1:0]   v;
    logic [SW-1:0]   sh;
    logic            sign;
    logic            big;
    logic            eq_w;
    logic [DW:0]     ext;
    logic [2*DW-1:0] dbl;

    assign v    = i_req.value;
    assign sh   = i_req.amount[SW-1:0];
    assign sign = v[DW-1];
    assign big  = |i_req.amount[AW-1:SW];
    assign eq_w = (i_req.amount == AW'(DW));

    // Shift by amount, with ARM rules for zero and for amounts of a word or more
    always_comb begin
        ext     = '0;
        dbl     = '0;
        o_opnd  = v;
        o_carry = i_req.cin;
        if (i_req.amount != '0) begin
            case (i_req.kind)
                adp_pkg::SH_LSL: begin
                    ext = {1'b0, v} << sh;
                    if (big) begin
                        o_opnd  = '0;
                        o_carry = eq_w ? v[0] : 1'b0;
                    end else begin
                        o_opnd  = ext[DW-1:0];
                        o_carry = ext[DW];
                    end
                end
                adp_pkg::SH_LSR: begin
                    ext = {v, 1'b0} >> sh;
                    if (big) begin
                        o_opnd  = '0;
                        o_carry = eq_w ? sign : 1'b0;
                    end else begin
                        o_opnd  = ext[DW:1];
                        o_carry = ext[0];
                    end
                end
                adp_pkg::SH_ASR: begin
                    ext = $unsigned($signed({v, 1'b0}) >>> sh);
                    if (big) begin
                        o_opnd  = {DW{sign}};
                        o_carry = sign;
                    end else begin
                        o_opnd  = ext[DW:1];
                        o_carry = ext[0];
                    end
                end
                adp_pkg::SH_ROR: begin
                    dbl = {v, v} >> sh;
                    if (sh == '0) begin
                        o_opnd  = v;
                        o_carry = sign;
                    end else begin
                        o_opnd  = dbl[DW-1:0];
                        o_carry = dbl[DW-1];
                    end
                end
                default: begin
                    o_opnd  = v;
                    o_carry = i_req.cin;
                end
            endcase
        end
    end

endmodule

// ===== rtl/adp_alu.sv =====
module adp_alu (
    input  logic [3:0]                   i_opcode,
    input  logic [adp_pkg::DATA_W-1:0]   i_rn,
    input  logic [adp_pkg::DATA_W-1:0]   i_opnd,
    input  logic                         i_shift_carry,
    input  logic                         i_cin,
    output adp_pkg::t_alu_res            o_res
);

    localparam int DW = adp_pkg::DATA_W;

    logic [DW:0]     sum;
    logic [DW:0]     diff;
    logic [DW:0]     rdiff;
    adp_pkg::t_opcode op;

    assign op = adp_pkg::t_opcode'(i_opcode);

    // One adder per direction; carry out of a subtract is no-borrow
    assign sum   = {1'b0, i_rn} + {1'b0, i_opnd};
    assign diff  = {1'b0, i_rn} + {1'b0, ~i_opnd} + (DW+1)'(1);
    assign rdiff = {1'b0, i_opnd} + {1'b0, ~i_rn} + (DW+1)'(1);

    always_comb begin
        o_res.res     = '0;
        o_res.carry   = i_cin;
        o_res.wr_en   = 1'b1;
        o_res.illegal = 1'b0;
        case (op)
            adp_pkg::OP_AND: begin
                o_res.res   = i_rn & i_opnd;
                o_res.carry = i_shift_carry;
            end
            adp_pkg::OP_EOR: begin
                o_res.res   = i_rn ^ i_opnd;
                o_res.carry = i_shift_carry;
            end
            adp_pkg::OP_SUB: begin
                o_res.res   = diff[DW-1:0];
                o_res.carry = diff[DW];
            end
            adp_pkg::OP_RSB: begin
                o_res.res   = rdiff[DW-1:0];
                o_res.carry = rdiff[DW];
            end
            adp_pkg::OP_ADD: begin
                o_res.res   = sum[DW-1:0];
                o_res.carry = sum[DW];
            end
            adp_pkg::OP_TST: begin
                o_res.res   = i_rn & i_opnd;
                o_res.carry = i_shift_carry;
                o_res.wr_en = 1'b0;
            end
            adp_pkg::OP_TEQ: begin
                o_res.res   = i_rn ^ i_opnd;
                o_res.carry = i_shift_carry;
                o_res.wr_en = 1'b0;
            end
            adp_pkg::OP_CMP: begin
                o_res.res   = diff[DW-1:0];
                o_res.carry = diff[DW];
                o_res.wr_en = 1'b0;
            end
            adp_pkg::OP_ORR: begin
                o_res.res   = i_rn | i_opnd;
                o_res.carry = i_shift_carry;
            end
            adp_pkg::OP_MOV: begin
                o_res.res   = i_opnd;
                o_res.carry = i_shift_carry;
            end
            default: begin
                o_res.wr_en   = 1'b0;
                o_res.illegal = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/arm_data_processing_alu_top.sv =====
// Data-processing execute unit with barrel shifter.
// i_in carries one instruction word with Rn, Rm, Rs values and the current
// NZCV flags; o_out returns the Rd value, Rd number, write enable, new flags
// and an illegal-opcode mark. Both channels move a word when valid and ready
// are high at a rising edge of i_clk.
// An accepted word passes four register stages (operand select, barrel
// shift, ALU, flag/writeback register), the first loaded at acceptance, and
// o_out.valid rises when it reaches the last. One word per cycle while the
// output is not stalled; the four register stages move together, so one
// word can enter every cycle that the pipe advances.
// Each stage's valid bit travels with its data. When the receiver holds
// o_out.ready low with a word waiting, the whole pipe freezes and i_in.ready
// drops; nothing is lost or repeated. Bubbles in the pipe are not squeezed
// out: while the output stage is empty, all stages advance together.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; the pipe is
// empty and ready as soon as reset is released.
// TST, TEQ, CMP and illegal opcodes give write_enable 0 and result 0; flags
// change only when the S bit is set, and V always passes through.
`include "arm_data_processing_alu_top_macros.svh"

module arm_data_processing_alu_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    adp_in_if.sink           i_in,
    adp_out_if.source        o_out
);

    localparam int DW = adp_pkg::DATA_W;
    localparam int AW = adp_pkg::AMT_W;
    localparam int FW = adp_pkg::FLAGS_W;
    localparam int RW = adp_pkg::REG_W;

    logic en;

    // stage 1: operand select
    logic                  r_v1;
    logic [3:0]            r_op1;
    logic                  r_s1;
    logic [RW-1:0]         r_rd1;
    logic [DW-1:0]         r_rn1;
    logic [FW-1:0]         r_fin1;
    adp_pkg::t_shift_req   r_req1;
    adp_pkg::t_shift_req   n_req1;

    // stage 2: shifted operand
    logic                  r_v2;
    logic [3:0]            r_op2;
    logic                  r_s2;
    logic [RW-1:0]         r_rd2;
    logic [DW-1:0]         r_rn2;
    logic [FW-1:0]         r_fin2;
    logic [DW-1:0]         r_opnd2;
    logic                  r_sc2;
    logic [DW-1:0]         n_opnd2;
    logic                  n_sc2;

    // stage 3: ALU result
    logic                  r_v3;
    logic                  r_s3;
    logic [RW-1:0]         r_rd3;
    logic [FW-1:0]         r_fin3;
    adp_pkg::t_alu_res     r_alu3;
    adp_pkg::t_alu_res     n_alu3;

    // stage 4: output word
    logic                  r_v4;
    logic [DW-1:0]         r_res4;
    logic [RW-1:0]         r_rd4;
    logic                  r_we4;
    logic [FW-1:0]         r_flags4;
    logic                  r_ill4;
    logic [FW-1:0]         n_flags4;

    // Whole pipe advances unless a finished word is held at the output
    assign en         = !r_v4 || o_out.ready;
    assign i_in.ready = en;

    // Operand 2 source: rotated immediate or shifted Rm
    always_comb begin
        n_req1.cin = i_in.flags_in[adp_pkg::FLAG_C];
        if (i_in.instruction[25]) begin
            n_req1.value  = DW'(i_in.instruction[7:0]);
            n_req1.kind   = adp_pkg::SH_ROR;
            n_req1.amount = AW'({i_in.instruction[11:8], 1'b0});
        end else begin
            n_req1.value  = i_in.rm_value;
            n_req1.kind   = adp_pkg::t_shift'(i_in.instruction[6:5]);
            n_req1.amount = i_in.instruction[4] ? i_in.rs_value[AW-1:0]
                                                : AW'(i_in.instruction[11:7]);
        end
    end

    adp_shifter u_shifter (
        .i_req   (r_req1),
        .o_opnd  (n_opnd2),
        .o_carry (n_sc2)
    );

    adp_alu u_alu (
        .i_opcode      (r_op2),
        .i_rn          (r_rn2),
        .i_opnd        (r_opnd2),
        .i_shift_carry (r_sc2),
        .i_cin         (r_fin2[adp_pkg::FLAG_C]),
        .o_res         (n_alu3)
    );

    // Flag update: only with S set on a legal opcode
    always_comb begin
        n_flags4 = r_fin3;
        if (r_s3 && !r_alu3.illegal) begin
            n_flags4[adp_pkg::FLAG_N] = r_alu3.res[DW-1];
            n_flags4[adp_pkg::FLAG_Z] = (r_alu3.res == '0);
            n_flags4[adp_pkg::FLAG_C] = r_alu3.carry;
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1    <= i_in.instruction[24:21];
            r_s1     <= i_in.instruction[20];
            r_rd1    <= i_in.instruction[15:12];
            r_rn1    <= i_in.rn_value;
            r_fin1   <= i_in.flags_in;
            r_req1   <= n_req1;

            r_op2    <= r_op1;
            r_s2     <= r_s1;
            r_rd2    <= r_rd1;
            r_rn2    <= r_rn1;
            r_fin2   <= r_fin1;
            r_opnd2  <= n_opnd2;
            r_sc2    <= n_sc2;

            r_s3     <= r_s2;
            r_rd3    <= r_rd2;
            r_fin3   <= r_fin2;
            r_alu3   <= n_alu3;

            r_res4   <= r_alu3.wr_en ? r_alu3.res : '0;
            r_rd4    <= r_rd3;
            r_we4    <= r_alu3.wr_en;
            r_flags4 <= n_flags4;
            r_ill4   <= r_alu3.illegal;
        end
    end

    assign o_out.valid        = r_v4;
    assign o_out.result_value = r_res4;
    assign o_out.dest_index   = r_rd4;
    assign o_out.write_enable = r_we4;
    assign o_out.flags_out    = r_flags4;
    assign o_out.illegal_op   = r_ill4;

    `ADP_ASSERT(a_illegal_no_write,
        o_out.valid && o_out.illegal_op |-> !o_out.write_enable && o_out.result_value == '0,
        "illegal opcode produced a register write")
    `ADP_ASSERT(a_nowrite_zero,
        o_out.valid && !o_out.write_enable |-> o_out.result_value == '0,
        "result not zero without write enable")
    `ADP_ASSERT(a_stall_keeps_alu,
        r_v3 && !en |=> r_v3 && $stable(r_alu3),
        "ALU stage word lost during stall")
    `ADP_ASSERT_RST(a_reset_empties,
        !i_rst_n |=> !o_out.valid && !r_v1,
        "pipe not empty after reset")

endmodule

// ===== verif/alu_check_pkg.sv =====
package alu_check_pkg;
    import adp_pkg::*;

    // One instruction word as it enters the execute unit
    typedef struct packed {
        logic [DATA_W-1:0]  instruction;
        logic [DATA_W-1:0]  rn_value;
        logic [DATA_W-1:0]  rm_value;
        logic [DATA_W-1:0]  rs_value;
        logic [FLAGS_W-1:0] flags_in;
    } t_dp_issue;

    // One writeback word as it leaves the execute unit
    typedef struct packed {
        logic [DATA_W-1:0]  result_value;
        logic [REG_W-1:0]   dest_index;
        logic               write_enable;
        logic [FLAGS_W-1:0] flags_out;
        logic               illegal_op;
    } t_dp_wb;

    localparam int MAX_SHOWN = 10;

    class dp_checker;
        t_dp_wb pending_writebacks[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Rotate right by n mod 32
        function logic [DATA_W-1:0] rotr(logic [DATA_W-1:0] v, int n);
            n = n % DATA_W;
            if (n == 0) begin
                return v;
            end
            return (v >> n) | (v << (DATA_W - n));
        endfunction

        // Barrel shifter on Rm, with carry-out
        function logic [DATA_W-1:0] shift_operand(logic [DATA_W-1:0] v, t_shift kind,
                                                  logic [AMT_W-1:0] amt, logic cin,
                                                  output logic cout);
            int n;
            n = amt;
            if (n == 0) begin
                cout = cin;
                return v;
            end
            case (kind)
                SH_LSL: begin
                    if (n < DATA_W) begin
                        cout = v[DATA_W - n];
                        return v << n;
                    end
                    cout = (n == DATA_W) ? v[0] : 1'b0;
                    return '0;
                end
                SH_LSR: begin
                    if (n < DATA_W) begin
                        cout = v[n - 1];
                        return v >> n;
                    end
                    cout = (n == DATA_W) ? v[DATA_W-1] : 1'b0;
                    return '0;
                end
                SH_ASR: begin
                    if (n < DATA_W) begin
                        cout = v[n - 1];
                        return $signed(v) >>> n;
                    end
                    cout = v[DATA_W-1];
                    return {DATA_W{v[DATA_W-1]}};
                end
                default: begin
                    // ROR: multiples of 32 leave the value, carry is the sign
                    if (n % DATA_W == 0) begin
                        cout = v[DATA_W-1];
                        return v;
                    end
                    cout = v[(n % DATA_W) - 1];
                    return rotr(v, n);
                end
            endcase
        endfunction

        // Expected writeback for one instruction word
        function t_dp_wb exec_dp_instr(t_dp_issue w);
            t_dp_wb            wb;
            logic [3:0]        op;
            logic              sbit;
            logic              cin;
            logic              shc;
            logic              c;
            logic              logical;
            logic              cmp_only;
            logic              bad_op;
            logic [DATA_W-1:0] opnd;
            logic [DATA_W-1:0] res;
            logic [AMT_W-1:0]  amt;
            int                rot;

            op       = w.instruction[24:21];
            sbit     = w.instruction[20];
            cin      = w.flags_in[FLAG_C];
            c        = cin;
            res      = '0;
            logical  = 1'b0;
            cmp_only = 1'b0;
            bad_op   = 1'b0;

            // operand 2
            if (w.instruction[25]) begin
                rot  = 2 * w.instruction[11:8];
                opnd = rotr({24'd0, w.instruction[7:0]}, rot);
                shc  = (rot == 0) ? cin : opnd[DATA_W-1];
            end else begin
                amt  = w.instruction[4] ? w.rs_value[7:0] : {3'd0, w.instruction[11:7]};
                opnd = shift_operand(w.rm_value, t_shift'(w.instruction[6:5]), amt, cin, shc);
            end

            case (op)
                OP_AND: begin res = w.rn_value & opnd; logical = 1'b1; end
                OP_EOR: begin res = w.rn_value ^ opnd; logical = 1'b1; end
                OP_SUB: begin res = w.rn_value - opnd; c = (w.rn_value >= opnd); end
                OP_RSB: begin res = opnd - w.rn_value; c = (opnd >= w.rn_value); end
                OP_ADD: begin {c, res} = {1'b0, w.rn_value} + {1'b0, opnd}; end
                OP_TST: begin res = w.rn_value & opnd; logical = 1'b1; cmp_only = 1'b1; end
                OP_TEQ: begin res = w.rn_value ^ opnd; logical = 1'b1; cmp_only = 1'b1; end
                OP_CMP: begin
                    res      = w.rn_value - opnd;
                    c        = (w.rn_value >= opnd);
                    cmp_only = 1'b1;
                end
                OP_ORR: begin res = w.rn_value | opnd; logical = 1'b1; end
                OP_MOV: begin res = opnd; logical = 1'b1; end
                default: bad_op = 1'b1;
            endcase
            if (logical) begin
                c = shc;
            end

            wb.dest_index   = w.instruction[15:12];
            wb.illegal_op   = bad_op;
            wb.write_enable = !bad_op && !cmp_only;
            wb.result_value = wb.write_enable ? res : '0;
            wb.flags_out    = w.flags_in;
            if (!bad_op && sbit) begin
                wb.flags_out[FLAG_N] = res[DATA_W-1];
                wb.flags_out[FLAG_Z] = (res == '0);
                wb.flags_out[FLAG_C] = c;
            end
            return wb;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("%s", msg);
            end
        endfunction

        function void note_issue(t_dp_issue w);
            pending_writebacks.push_back(exec_dp_instr(w));
        endfunction

        function void check_writeback(t_dp_wb got);
            t_dp_wb want;
            if (pending_writebacks.size() == 0) begin
                flag_error($sformatf("unexpected writeback: res=%h rd=%0d we=%b f=%h ill=%b",
                                     got.result_value, got.dest_index, got.write_enable,
                                     got.flags_out, got.illegal_op));
                return;
            end
            want = pending_writebacks.pop_front();
            if (got.result_value !== want.result_value || got.dest_index !== want.dest_index ||
                got.write_enable !== want.write_enable || got.flags_out !== want.flags_out ||
                got.illegal_op !== want.illegal_op) begin
                flag_error($sformatf({"writeback mismatch: exp res=%h rd=%0d we=%b f=%h ill=%b",
                                      " / got res=%h rd=%0d we=%b f=%h ill=%b"},
                                     want.result_value, want.dest_index, want.write_enable,
                                     want.flags_out, want.illegal_op,
                                     got.result_value, got.dest_index, got.write_enable,
                                     got.flags_out, got.illegal_op));
            end
        endfunction

        function int pending();
            return pending_writebacks.size();
        endfunction
    endclass

endpackage

// ===== verif/tb_arm_data_processing_alu_top.sv =====
module tb_arm_data_processing_alu_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adp_pkg::*;
    import alu_check_pkg::*;

    localparam int         LATENCY     = 4;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 40;
    localparam int         PHASE_WORDS = 160;
    localparam logic [3:0] COND_ALWAYS = 4'hE;
    localparam logic [3:0] ILLEGAL_OPS [6] = '{4'd5, 4'd6, 4'd7, 4'd11, 4'd14, 4'd15};
    localparam logic [3:0] LEGAL_OPS [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
                                              OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};

    logic i_clk = 1'b0;
    logic i_rst_n;

    adp_in_if  in_if();
    adp_out_if out_if();

    arm_data_processing_alu_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    dp_checker chk = new();

    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_off;
    int   cycle_cnt;
    event hold_go;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_go);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // Monitors
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            chk.note_issue(t_dp_issue'{in_if.instruction, in_if.rn_value, in_if.rm_value,
                                       in_if.rs_value, in_if.flags_in});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            chk.check_writeback(t_dp_wb'{out_if.result_value, out_if.dest_index,
                                         out_if.write_enable, out_if.flags_out,
                                         out_if.illegal_op});
        end
    end

    // Watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] dp_instr(logic imm, logic [3:0] op, logic s,
                                             logic [3:0] rn, logic [3:0] rd,
                                             logic [11:0] op2);
        return {COND_ALWAYS, 2'b00, imm, op, s, rn, rd, op2};
    endfunction

    function automatic t_dp_issue mk_word(logic [31:0] ins, logic [31:0] rn,
                                          logic [31:0] rm, logic [31:0] rs,
                                          logic [3:0] flags);
        return t_dp_issue'{ins, rn, rm, rs, flags};
    endfunction

    // Operand values biased toward the edges
    function automatic logic [31:0] pick_data();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_dp_issue rand_word();
        t_dp_issue w;
        w.instruction = $urandom;
        if ($urandom_range(7) == 0) begin
            w.instruction[24:21] = ILLEGAL_OPS[$urandom_range(5)];
        end else begin
            w.instruction[24:21] = LEGAL_OPS[$urandom_range(9)];
        end
        if ($urandom_range(7) == 0) begin
            w.instruction[11:7] = 5'd0;
        end
        w.rn_value = pick_data();
        w.rm_value = pick_data();
        w.rs_value = $urandom;
        case ($urandom_range(3))
            0: w.rs_value[7:0] = 8'd0;
            1: w.rs_value[7:0] = 8'($urandom_range(1, 31));
            2: w.rs_value[7:0] = 8'd32;
            default: w.rs_value[7:0] = 8'($urandom_range(33, 255));
        endcase
        // equal operands hit the borrow boundary
        if ($urandom_range(7) == 0) begin
            w.rn_value = w.rm_value;
        end
        w.flags_in = 4'($urandom);
        return w;
    endfunction

    // Offer one word, honoring the sender idle rate; returns after acceptance
    task automatic send_word(input t_dp_issue w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.instruction <= w.instruction;
        in_if.rn_value    <= w.rn_value;
        in_if.rm_value    <= w.rm_value;
        in_if.rs_value    <= w.rs_value;
        in_if.flags_in    <= w.flags_in;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(rand_word());
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.instruction = '0;
        in_if.rn_value    = '0;
        in_if.rm_value    = '0;
        in_if.rs_value    = '0;
        in_if.flags_in    = '0;
        out_if.ready      = 1'b0;
        hold_off          = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: immediates, every opcode, carry corners, shift corners
        send_word(mk_word(dp_instr(1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, {4'd0, 8'hFF}),
                          32'h0, 32'h0, 32'h0, 4'b0010));
        send_word(mk_word(dp_instr(1'b1, OP_MOV, 1'b1, 4'd0, 4'd2, {4'd1, 8'h03}),
                          32'h0, 32'h0, 32'h0, 4'b0000));
        send_word(mk_word(dp_instr(1'b1, OP_ADD, 1'b1, 4'd3, 4'd3, {4'd0, 8'h01}),
                          32'hFFFF_FFFF, 32'h0, 32'h0, 4'b0001));
        send_word(mk_word(dp_instr(1'b1, OP_SUB, 1'b1, 4'd4, 4'd4, {4'd0, 8'h05}),
                          32'h5, 32'h0, 32'h0, 4'b1000));
        send_word(mk_word(dp_instr(1'b0, OP_RSB, 1'b1, 4'd5, 4'd5,
                                   {5'd0, SH_LSL, 1'b0, 4'd6}),
                          32'h1234, 32'h1234, 32'h0, 4'b0000));
        send_word(mk_word(dp_instr(1'b1, OP_CMP, 1'b1, 4'd6, 4'd7, {4'd0, 8'h02}),
                          32'h1, 32'h0, 32'h0, 4'b0110));
        send_word(mk_word(dp_instr(1'b0, OP_TST, 1'b1, 4'd7, 4'd8,
                                   {5'd4, SH_ROR, 1'b0, 4'd1}),
                          32'hFFFF_FFFF, 32'h0000_000F, 32'h0, 4'b0000));
        send_word(mk_word(dp_instr(1'b0, OP_TEQ, 1'b1, 4'd8, 4'd9,
                                   {5'd0, SH_LSL, 1'b0, 4'd2}),
                          32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'h0, 4'b0011));
        send_word(mk_word(dp_instr(1'b0, OP_AND, 1'b0, 4'd9, 4'd10,
                                   {5'd3, SH_LSR, 1'b0, 4'd3}),
                          32'hF0F0_F0F0, 32'hFFFF_0000, 32'h0, 4'b1111));
        send_word(mk_word(dp_instr(1'b0, OP_EOR, 1'b1, 4'd10, 4'd11,
                                   {5'd1, SH_LSL, 1'b0, 4'd4}),
                          32'h0, 32'h8000_0000, 32'h0, 4'b0000));
        send_word(mk_word(dp_instr(1'b1, OP_ORR, 1'b0, 4'd11, 4'd12, {4'hF, 8'hA5}),
                          32'h1, 32'h0, 32'h0, 4'b0101));
        // register-amount shifts at and past the word width
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd13,
                                   {4'd2, 1'b0, SH_LSL, 1'b1, 4'd5}),
                          32'h0, 32'h0000_0001, 32'd32, 4'b0000));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd14,
                                   {4'd2, 1'b0, SH_LSL, 1'b1, 4'd5}),
                          32'h0, 32'hFFFF_FFFF, 32'd33, 4'b0010));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd15,
                                   {4'd2, 1'b0, SH_LSR, 1'b1, 4'd5}),
                          32'h0, 32'h8000_0000, 32'd32, 4'b0000));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd0,
                                   {4'd2, 1'b0, SH_LSR, 1'b1, 4'd5}),
                          32'h0, 32'hFFFF_FFFF, 32'd200, 4'b0010));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd1,
                                   {4'd2, 1'b0, SH_ASR, 1'b1, 4'd5}),
                          32'h0, 32'h8000_0001, 32'd40, 4'b0000));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd2,
                                   {4'd2, 1'b0, SH_ROR, 1'b1, 4'd5}),
                          32'h0, 32'h8000_0000, 32'd64, 4'b0000));
        // shift by zero keeps carry: register byte zero, then immediate zero; then ASR by 31
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd3,
                                   {4'd2, 1'b0, SH_ROR, 1'b1, 4'd5}),
                          32'h0, 32'h8000_0000, 32'hFFFF_FF00, 4'b0010));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd4,
                                   {5'd0, SH_LSR, 1'b0, 4'd5}),
                          32'h0, 32'h8000_0000, 32'h0, 4'b0010));
        send_word(mk_word(dp_instr(1'b0, OP_MOV, 1'b1, 4'd0, 4'd5,
                                   {5'd31, SH_ASR, 1'b0, 4'd5}),
                          32'h0, 32'h8000_0000, 32'h0, 4'b0000));
        // illegal opcodes change nothing
        foreach (ILLEGAL_OPS[i]) begin
            send_word(mk_word(dp_instr(1'b1, ILLEGAL_OPS[i], 1'b1, 4'd1, 4'(i), {4'd0, 8'h0}),
                              32'h0, 32'h0, 32'h0, 4'($urandom)));
        end

        // Back-pressure: receiver holds off while sender keeps offering
        -> hold_go;
        send_random(PHASE_WORDS);
        wait_drained();

        // Sender sparse
        send_idle_pct = 83;
        send_random(PHASE_WORDS);

        // Receiver sparse
        send_idle_pct  = 0;
        recv_stall_pct <= 83;
        send_random(PHASE_WORDS);

        // Light idling on both sides
        send_idle_pct  = 7;
        recv_stall_pct <= 7;
        send_random(PHASE_WORDS);

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);

        if (chk.pending() != 0) begin
            chk.flag_error($sformatf("%0d writebacks never arrived", chk.pending()));
        end
        if (chk.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/adp_pkg.sv
rtl/adp_intf.sv
rtl/adp_shifter.sv
rtl/adp_alu.sv
rtl/arm_data_processing_alu_top.sv
verif/alu_check_pkg.sv
verif/tb_arm_data_processing_alu_top.sv
